// ===== rtl/dstop_pkg.sv =====
// dstop_pkg: shared types and constants of the decaying score top select unit
// holds field widths, opcodes, controller states and the decay digit constants
// no dependencies
package dstop_pkg;

   // transaction field widths
   localparam int OPCODE_W  = 2;
   localparam int INDEX_W   = 5;
   localparam int VALUE_W   = 32;
   localparam int MASK_W    = 32;
   localparam int ENTRIES_W = 6;

   // parameter defaults
   localparam int MAX_ENTRIES_DEF = 32;
   localparam int SCORE_WIDTH_DEF = 32;

   // reset value of the tracked entry count
   localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 6'd32;

   // divide by ten, one hex digit per stage
   localparam int DIGIT_W       = 4;
   localparam int REM_W         = 4;
   localparam int STEP_W        = REM_W + DIGIT_W;
   localparam int PROD_W        = 16;
   localparam int DECAY_DIVISOR = 10;
   localparam int RECIP_MUL     = 205;   // 205 / 2048 is ten's reciprocal, exact below 1024
   localparam int RECIP_SHIFT   = 11;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_SET   = 2'd1,
      OP_DECAY = 2'd2,
      OP_QUERY = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic shift;
      logic clear;
      logic load;
   } cell_ctrl_type;

endpackage

// ===== rtl/dstop_cell.sv =====
// dstop_cell: one score cell of the rotating score chain
// depends on dstop_pkg for the cell control struct
module dstop_cell #(
   parameter int SCORE_W = dstop_pkg::SCORE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dstop_pkg::cell_ctrl_type ctrl,
   input  logic [SCORE_W-1:0]       nbr_score,
   input  logic [SCORE_W-1:0]       load_score,
   output logic [SCORE_W-1:0]       score
);

   logic [SCORE_W-1:0] score_ff;
   logic [SCORE_W-1:0] score_in;

   always_comb begin
      score_in = score_ff;
      if (ctrl.clear) begin
         score_in = '0;
      end else if (ctrl.load) begin
         score_in = load_score;
      end else if (ctrl.shift) begin
         score_in = nbr_score;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff <= '0;
      end else begin
         score_ff <= score_in;
      end
   end

   assign score = score_ff;

endmodule

// ===== rtl/dstop_div_stage.sv =====
// dstop_div_stage: one digit step of the divide-by-ten pipeline in the ring
// depends on dstop_pkg for digit widths and the reciprocal constants
module dstop_div_stage #(
   parameter int PAD_W     = dstop_pkg::SCORE_WIDTH_DEF,
   parameter int DIGIT_POS = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift_en,
   input  logic [PAD_W-1:0]             val_i,
   input  logic [dstop_pkg::REM_W-1:0]  rem_i,
   input  logic                         div_i,
   output logic [PAD_W-1:0]             val_o,
   output logic [dstop_pkg::REM_W-1:0]  rem_o,
   output logic                         div_o
);

   localparam int LSB = DIGIT_POS * dstop_pkg::DIGIT_W;

   logic [PAD_W-1:0]                  val_ff, val_in;
   logic [dstop_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic                              div_ff, div_in;
   logic [dstop_pkg::STEP_W-1:0]      step_v;
   logic [dstop_pkg::PROD_W-1:0]      prod;
   logic [dstop_pkg::DIGIT_W-1:0]     quot;
   logic [dstop_pkg::STEP_W-1:0]      back;

   always_comb begin
      // partial remainder times sixteen plus the next digit, at most 159
      step_v = {rem_i, val_i[LSB +: dstop_pkg::DIGIT_W]};
      prod   = dstop_pkg::PROD_W'(step_v) * dstop_pkg::PROD_W'(dstop_pkg::RECIP_MUL);
      quot   = prod[dstop_pkg::RECIP_SHIFT +: dstop_pkg::DIGIT_W];
      back   = step_v - dstop_pkg::STEP_W'(quot)
                        * dstop_pkg::STEP_W'(dstop_pkg::DECAY_DIVISOR);
      val_in = val_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (shift_en) begin
         val_in = val_i;
         rem_in = rem_i;
         div_in = div_i;
         if (div_i) begin
            val_in[LSB +: dstop_pkg::DIGIT_W] = quot;
            rem_in = back[dstop_pkg::REM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= 1'b0;
      end else begin
         div_ff <= div_in;
      end
      val_ff <= val_in;
      rem_ff <= rem_in;
   end

   assign val_o = val_ff;
   assign rem_o = rem_ff;
   assign div_o = div_ff;

endmodule

// ===== rtl/decaying_score_top_select_unit.sv =====
// decaying_score_top_select_unit: top level of the decaying score top select block
// depends on dstop_pkg, dstop_cell and dstop_div_stage
//
// Keeps one unsigned 16.16 score per table entry in a ring of score cells.
// Clear zeroes all scores, set writes one score (ignored at or beyond the
// tracked entry count), decay divides every tracked score by ten with
// truncation, and query returns the eligible tracked entry with the highest
// score, lowest index on ties; every transaction gives one response, all
// zero except for a query that found an entry. Decay and query run the
// scores through one full turn of the ring, which holds the cells plus a
// divide-by-ten pipeline of one stage per hex digit, and the query
// compare sits at the head of the ring. A new request is taken while the
// previous response still waits on rsp_ready. Writing csr_wr_data sets
// the tracked entry count (reset value 32) and zeroes the table; the user
// must write it only while the block is idle, as the block itself does
// not enforce this. Reset is synchronous and clears the table too.
module decaying_score_top_select_unit #(
   parameter int MAX_ENTRIES = dstop_pkg::MAX_ENTRIES_DEF,
   parameter int SCORE_WIDTH = dstop_pkg::SCORE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [dstop_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [dstop_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic [dstop_pkg::VALUE_W-1:0]    req_score_value,
   input  logic [dstop_pkg::MASK_W-1:0]     req_eligible_mask,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   output logic [dstop_pkg::INDEX_W-1:0]    rsp_top_index,
   output logic [dstop_pkg::VALUE_W-1:0]    rsp_top_score,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [dstop_pkg::ENTRIES_W-1:0]  csr_wr_data
);

   // ring geometry: cells then one divide stage per hex digit
   localparam int NDIG    = (SCORE_WIDTH + dstop_pkg::DIGIT_W - 1) / dstop_pkg::DIGIT_W;
   localparam int PAD_W   = NDIG * dstop_pkg::DIGIT_W;
   localparam int RING_N  = MAX_ENTRIES + NDIG;
   localparam int CNT_W   = ($clog2(RING_N) > dstop_pkg::INDEX_W) ?
                            $clog2(RING_N) : dstop_pkg::INDEX_W;
   localparam int CMP_W   = (CNT_W > dstop_pkg::ENTRIES_W) ? CNT_W : dstop_pkg::ENTRIES_W;

   // controller state
   dstop_pkg::state_type                 state_ff, state_in;
   dstop_pkg::opcode_type                op_ff, op_in;
   logic [CNT_W-1:0]                     step_ff, step_in;
   logic [dstop_pkg::MASK_W-1:0]         mask_ff, mask_in;
   logic                                 have_ff, have_in;
   logic [dstop_pkg::INDEX_W-1:0]        best_idx_ff, best_idx_in;
   logic [SCORE_WIDTH-1:0]               best_score_ff, best_score_in;
   logic [dstop_pkg::ENTRIES_W-1:0]      entries_ff, entries_in;

   // response register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_found_ff, rsp_found_in;
   logic [dstop_pkg::INDEX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [dstop_pkg::VALUE_W-1:0]        rsp_score_ff, rsp_score_in;

   // ring signals
   logic [SCORE_WIDTH-1:0]               cell_score [MAX_ENTRIES];
   dstop_pkg::cell_ctrl_type             cell_ctrl  [MAX_ENTRIES];
   logic [PAD_W-1:0]                     stg_val    [NDIG+1];
   logic [dstop_pkg::REM_W-1:0]          stg_rem    [NDIG+1];
   logic                                 stg_div    [NDIG+1];

   logic                                 req_take;
   logic                                 ring_shift;
   logic                                 table_clear;
   logic                                 set_hit;
   logic                                 head_tracked;
   logic                                 head_eligible;
   logic [SCORE_WIDTH-1:0]               head_score;
   logic [SCORE_WIDTH-1:0]               set_score;

   assign req_ready  = (state_ff == dstop_pkg::ST_IDLE);
   assign req_take   = req_valid && req_ready;
   assign ring_shift = (state_ff == dstop_pkg::ST_RUN);
   assign head_score = cell_score[0];
   assign set_score  = SCORE_WIDTH'(req_score_value);

   // clear on a clear transaction or any count write
   assign table_clear = csr_wr_en ||
                        (req_take && (dstop_pkg::opcode_type'(req_opcode) == dstop_pkg::OP_CLEAR));

   // set lands only inside the tracked range
   assign set_hit = req_take &&
                    (dstop_pkg::opcode_type'(req_opcode) == dstop_pkg::OP_SET) &&
                    (CMP_W'(req_entry_index) < CMP_W'(entries_ff)) &&
                    (CMP_W'(req_entry_index) < CMP_W'(MAX_ENTRIES));

   // the head cell holds the entry whose index equals the step count
   assign head_tracked  = ring_shift &&
                          (CMP_W'(step_ff) < CMP_W'(entries_ff)) &&
                          (CMP_W'(step_ff) < CMP_W'(MAX_ENTRIES));
   assign head_eligible = head_tracked && (op_ff == dstop_pkg::OP_QUERY) && mask_ff[0];

   // score cells, shifting toward the head
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [SCORE_WIDTH-1:0] nbr;
      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign nbr = stg_val[NDIG][SCORE_WIDTH-1:0];
      end else begin : g_mid
         assign nbr = cell_score[i+1];
      end
      assign cell_ctrl[i].shift = ring_shift;
      assign cell_ctrl[i].clear = table_clear;
      assign cell_ctrl[i].load  = set_hit && (32'(req_entry_index) == 32'(i));

      dstop_cell #(
         .SCORE_W (SCORE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[i]),
         .nbr_score  (nbr),
         .load_score (set_score),
         .score      (cell_score[i])
      );
   end

   // divide-by-ten pipeline from head back to tail, most significant digit first
   assign stg_val[0] = PAD_W'(head_score);
   assign stg_rem[0] = '0;
   assign stg_div[0] = head_tracked && (op_ff == dstop_pkg::OP_DECAY);

   for (genvar s = 0; s < NDIG; s++) begin : g_div
      dstop_div_stage #(
         .PAD_W     (PAD_W),
         .DIGIT_POS (NDIG - 1 - s)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .shift_en (ring_shift),
         .val_i    (stg_val[s]),
         .rem_i    (stg_rem[s]),
         .div_i    (stg_div[s]),
         .val_o    (stg_val[s+1]),
         .rem_o    (stg_rem[s+1]),
         .div_o    (stg_div[s+1])
      );
   end

   // controller: next state and datapath control
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      step_in       = step_ff;
      mask_in       = mask_ff;
      have_in       = have_ff;
      best_idx_in   = best_idx_ff;
      best_score_in = best_score_ff;
      entries_in    = entries_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_score_in  = rsp_score_ff;

      if (csr_wr_en) begin
         entries_in = csr_wr_data;
      end

      // response register drains when taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         dstop_pkg::ST_IDLE: begin
            if (req_take) begin
               op_in         = dstop_pkg::opcode_type'(req_opcode);
               step_in       = '0;
               mask_in       = req_eligible_mask;
               have_in       = 1'b0;
               best_idx_in   = '0;
               best_score_in = '0;
               unique case (dstop_pkg::opcode_type'(req_opcode)) inside
                  dstop_pkg::OP_DECAY,
                  dstop_pkg::OP_QUERY: state_in = dstop_pkg::ST_RUN;
                  default:             state_in = dstop_pkg::ST_DONE;
               endcase
            end
         end
         dstop_pkg::ST_RUN: begin
            // one turn of the ring, compare at the head
            step_in = step_ff + CNT_W'(1);
            mask_in = mask_ff >> 1;
            if (head_eligible && (!have_ff || (head_score > best_score_ff))) begin
               have_in       = 1'b1;
               best_idx_in   = step_ff[dstop_pkg::INDEX_W-1:0];
               best_score_in = head_score;
            end
            if (step_ff == CNT_W'(RING_N - 1)) begin
               state_in = dstop_pkg::ST_DONE;
            end
         end
         dstop_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = have_ff;
               rsp_index_in = best_idx_ff;
               rsp_score_in = dstop_pkg::VALUE_W'(best_score_ff);
               state_in     = dstop_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dstop_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dstop_pkg::ST_IDLE;
         entries_ff   <= dstop_pkg::ENTRIES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entries_ff   <= entries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      step_ff       <= step_in;
      mask_ff       <= mask_in;
      have_ff       <= have_in;
      best_idx_ff   <= best_idx_in;
      best_score_ff <= best_score_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_score_ff  <= rsp_score_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_top_index = rsp_index_ff;
   assign rsp_top_score = rsp_score_ff;

endmodule

// ===== rtl/dstop_checker.sv =====
// dstop_checker: port-level assertions for the decaying score top select unit
// depends on dstop_pkg; bound to decaying_score_top_select_unit below
module dstop_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [dstop_pkg::OPCODE_W-1:0]   req_opcode,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_found,
   input logic [dstop_pkg::INDEX_W-1:0]    rsp_top_index,
   input logic [dstop_pkg::VALUE_W-1:0]    rsp_top_score
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
                                  $stable(rsp_top_index) && $stable(rsp_top_score))
      else $error("response changed while stalled");

   // one transaction in flight: ready drops right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // an empty response carries zero index and score
   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_top_index == '0) && (rsp_top_score == '0))
      else $error("response without a find carries data");

   // a clear or set passes through the done state and then answers without a find when the response side is free
   a_short_ops: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid &&
      ((req_opcode == dstop_pkg::OP_CLEAR) || (req_opcode == dstop_pkg::OP_SET))
      |=> ##1 rsp_valid && !rsp_found)
      else $error("clear or set response missing");

endmodule

bind decaying_score_top_select_unit dstop_checker u_dstop_checker (.*);
